// ===== src/ksm_pkg.sv =====
// Shared types and constants of the scalar Kalman smoother.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none
package ksm_pkg;

   // Sample and estimate format: signed fixed point
   typedef logic signed [31:0] sample_type;

   // Default number of fraction bits in a sample
   localparam int SAMPLE_FRAC_BITS_DEF = 16;

   // Configuration port shape and register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THRESHOLD = 2'd2;

   // Q1.30 constants
   localparam logic [30:0] ONE_Q30   = 31'd1073741824;
   localparam logic [30:0] BLEND_Q30 = 31'd410169377;   // 0.382

   // Reset values
   localparam logic [30:0] Q_RESET   = 31'd107374;      // about 0.0001
   localparam logic [31:0] R_RESET   = 32'd107374182;   // about 0.1
   localparam logic [31:0] COV_RESET = 32'd1073741824;  // 1.0

endpackage
`default_nettype wire

// ===== src/ksm_if.sv =====
// Valid/ready channel interfaces for the smoother's sample and estimate items.
// Depends on ksm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ksm_req_if;
   import ksm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface ksm_rsp_if;
   import ksm_pkg::*;
   logic       valid;
   logic       ready;
   sample_type estimate;
   modport source (output valid, output estimate, input ready);
   modport sink   (input valid, input estimate, output ready);
endinterface
`default_nettype wire

// ===== src/scalar_kalman_smoother_top.sv =====
// Scalar Kalman smoother with jump rule, bit-serial divider and multipliers.
// Depends on ksm_pkg and the channel interfaces in ksm_if.sv.
//
// One sample item in, one estimate item out. After an item is accepted, the
// block runs a prep step; a restoring divider that produces the gain one
// quotient bit per cycle, with the blend product running alongside it on a
// shift-add multiplier; a step to form the gain and the prediction; two
// shift-add multipliers, one for gain times deviation and one for
// one-minus-gain times predicted covariance; and a finish step that loads
// the estimate into the output register. The block goes back to idle with
// the load and takes no new item before it is through with the last one.
// The next sample is accepted while the previous estimate still waits in
// the output register. The finish step stalls only if that register is
// full and not being read. Configuration writes are taken in any cycle but
// belong to idle periods.
`timescale 1ns / 1ps
`default_nettype none
module scalar_kalman_smoother_top #(
   parameter int SAMPLE_FRAC_BITS = ksm_pkg::SAMPLE_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ksm_req_if.sink                            req_chan,
   ksm_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [ksm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ksm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ksm_pkg::*;

   localparam logic [30:0] THR_RESET = 31'(1) << SAMPLE_FRAC_BITS;
   localparam int          ITERS     = 31;
   localparam int          CNT_W     = $clog2(ITERS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERS - 1);

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_GAIN = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [30:0]       q_ff, q_in;
   logic [31:0]       r_ff, r_in;
   logic [30:0]       thr_ff, thr_in;
   logic [31:0]       est_ff, est_in;
   logic [31:0]       cov_ff, cov_in;
   logic [32:0]       d_ff, d_in;
   logic [32:0]       pp_ff, pp_in;
   logic [33:0]       den_ff, den_in;
   logic              jump_ff, jump_in;
   logic              den_zero_ff, den_zero_in;
   logic [33:0]       rem_ff, rem_in;
   logic [30:0]       nbits_ff, nbits_in;
   logic [30:0]       quot_ff, quot_in;
   logic [34:0]       pred_ff, pred_in;
   logic [30:0]       mpl_a_ff, mpl_a_in;
   logic [63:0]       mcd_a_ff, mcd_a_in;
   logic [63:0]       acc_a_ff, acc_a_in;
   logic [30:0]       mpl_b_ff, mpl_b_in;
   logic [63:0]       mcd_b_ff, mcd_b_in;
   logic [63:0]       acc_b_ff, acc_b_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_est_ff, rsp_est_in;

   // Datapath temporaries
   logic        req_fire;
   logic [32:0] abs_dev;
   logic [63:0] numer;
   logic [34:0] trial;
   logic        qbit;
   logic [30:0] gain_sel;
   logic [63:0] acc_a_rnd, acc_b_rnd;
   logic [33:0] round_a, round_b;
   logic [35:0] est_sum;
   logic [31:0] est_sat;
   logic [31:0] cov_sat;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign req_fire         = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.estimate = rsp_est_ff;

   // Round half up at 2^-30: add half an LSB, keep bits 63..30
   assign acc_a_rnd = acc_a_ff + (64'd1 << 29);
   assign acc_b_rnd = acc_b_ff + (64'd1 << 29);
   assign round_a   = acc_a_rnd[63:30];
   assign round_b   = acc_b_rnd[63:30];

   // Absolute deviation, divider numerator and trial subtract
   assign abs_dev = d_ff[32] ? 33'(-d_ff) : d_ff;
   assign numer   = {1'b0, pp_ff, 30'b0} + {31'b0, den_ff[33:1]};
   assign trial   = {rem_ff, nbits_ff[30]};
   assign qbit    = (trial >= {1'b0, den_ff});

   // Gain: forced to 1.0 on a zero denominator, never above 1.0
   assign gain_sel = den_zero_ff ? ONE_Q30 :
                     ((quot_ff > ONE_Q30) ? ONE_Q30 : quot_ff);

   // Final estimate with saturation to the 32-bit range
   assign est_sum = {pred_ff[34], pred_ff} + {{2{round_a[33]}}, round_a};
   always_comb begin
      if ((est_sum[35:31] == 5'b00000) || (est_sum[35:31] == 5'b11111)) begin
         est_sat = est_sum[31:0];
      end else if (est_sum[35]) begin
         est_sat = 32'h8000_0000;
      end else begin
         est_sat = 32'h7FFF_FFFF;
      end
   end

   // New covariance, saturated to 32 bits unsigned
   assign cov_sat = (round_b[33:32] != 2'b00) ? 32'hFFFF_FFFF : round_b[31:0];

   // Next-state logic
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      thr_in       = thr_ff;
      est_in       = est_ff;
      cov_in       = cov_ff;
      d_in         = d_ff;
      pp_in        = pp_ff;
      den_in       = den_ff;
      jump_in      = jump_ff;
      den_zero_in  = den_zero_ff;
      rem_in       = rem_ff;
      nbits_in     = nbits_ff;
      quot_in      = quot_ff;
      pred_in      = pred_ff;
      mpl_a_in     = mpl_a_ff;
      mcd_a_in     = mcd_a_ff;
      acc_a_in     = acc_a_ff;
      mpl_b_in     = mpl_b_ff;
      mcd_b_in     = mcd_b_ff;
      acc_b_in     = acc_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_est_in   = rsp_est_ff;

      // Register writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PROCESS_NOISE:  q_in   = csr_wdata[30:0];
            CSR_MEASURE_NOISE:  r_in   = csr_wdata[31:0];
            CSR_JUMP_THRESHOLD: thr_in = csr_wdata[30:0];
            default: ;
         endcase
      end

      // Shift-add multiplier steps, one multiplier bit per cycle
      if ((state_ff == ST_DIV) || (state_ff == ST_MUL)) begin
         if (mpl_a_ff[0]) acc_a_in = acc_a_ff + mcd_a_ff;
         mcd_a_in = mcd_a_ff << 1;
         mpl_a_in = mpl_a_ff >> 1;
         if (mpl_b_ff[0]) acc_b_in = acc_b_ff + mcd_b_ff;
         mcd_b_in = mcd_b_ff << 1;
         mpl_b_in = mpl_b_ff >> 1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               d_in     = {req_chan.sample[31], req_chan.sample} - {est_ff[31], est_ff};
               pp_in    = {1'b0, cov_ff} + {2'b0, q_ff};
               den_in   = {2'b0, cov_ff} + {3'b0, q_ff} + {2'b0, r_ff};
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            jump_in     = (abs_dev >= {2'b0, thr_ff});
            den_zero_in = (den_ff == 34'd0);
            // quotient stays below 2^31, so the top 33 bits are below den
            rem_in      = {1'b0, numer[63:31]};
            nbits_in    = numer[30:0];
            quot_in     = '0;
            mpl_a_in    = BLEND_Q30;
            mcd_a_in    = {{31{d_ff[32]}}, d_ff};
            acc_a_in    = '0;
            cnt_in      = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            rem_in   = qbit ? 34'(trial - {1'b0, den_ff}) : trial[33:0];
            quot_in  = {quot_ff[29:0], qbit};
            nbits_in = nbits_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            // Prediction from the finished blend product
            if (jump_ff) begin
               pred_in = {{3{est_ff[31]}}, est_ff} + {round_a[33], round_a};
            end else begin
               pred_in = {{3{est_ff[31]}}, est_ff};
            end
            mpl_a_in = gain_sel;
            mcd_a_in = {{31{d_ff[32]}}, d_ff};
            acc_a_in = '0;
            mpl_b_in = ONE_Q30 - gain_sel;
            mcd_b_in = {31'b0, pp_ff};
            acc_b_in = '0;
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_est_in   = est_sat;
               est_in       = est_sat;
               cov_in       = cov_sat;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         q_ff         <= Q_RESET;
         r_ff         <= R_RESET;
         thr_ff       <= THR_RESET;
         est_ff       <= '0;
         cov_ff       <= COV_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         q_ff         <= q_in;
         r_ff         <= r_in;
         thr_ff       <= thr_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      d_ff        <= d_in;
      pp_ff       <= pp_in;
      den_ff      <= den_in;
      jump_ff     <= jump_in;
      den_zero_ff <= den_zero_in;
      rem_ff      <= rem_in;
      nbits_ff    <= nbits_in;
      quot_ff     <= quot_in;
      pred_ff     <= pred_in;
      mpl_a_ff    <= mpl_a_in;
      mcd_a_ff    <= mcd_a_in;
      acc_a_ff    <= acc_a_in;
      mpl_b_ff    <= mpl_b_in;
      mcd_b_ff    <= mcd_b_in;
      acc_b_ff    <= acc_b_in;
      rsp_est_ff  <= rsp_est_in;
   end

   // Checks
   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_PREP))
      else $error("accepted item did not start prep");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && !den_zero_ff) |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_GAIN) && !den_zero_ff) |-> (quot_ff <= ONE_Q30))
      else $error("gain quotient above 1.0");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("estimate item raised outside finish cycle");

endmodule
`default_nettype wire
